/* rtl/crpc_pkg.sv */
`default_nettype none

package crpc_pkg;

    // Number of CORDIC micro-rotations and the size of the arctangent table.
    localparam int CordicSteps = 16;
    localparam int AtanEntries = 24;
    localparam int NumCells    = (CordicSteps < AtanEntries) ? CordicSteps : AtanEntries;
    localparam int ShiftW      = $clog2(AtanEntries);

    // Input coordinates are 16-bit integers, results are 17-bit.
    localparam int InW  = 16;
    localparam int ResW = 17;
    localparam int FracW = 16;

    // Datapath: 18 integer bits cover the CORDIC gain on a full-scale vector.
    localparam int DataW = 34;
    localparam int AngW  = 32;

    // Gain correction, round(0.60725293500888 * 2^30), and output limit.
    localparam int KinvW = 30;
    localparam logic [KinvW-1:0] KINV = 30'd652032874;
    localparam int OutLimit = 46341;

    // Split of the datapath word for the gain multiplication.
    localparam int LoW   = 17;
    localparam int HiW   = DataW - LoW;
    localparam int HiPW  = HiW + KinvW + 1;
    localparam int LoPW  = LoW + KinvW;
    localparam int SumW  = HiPW + LoW + 1;
    localparam int RoundShift = 46;
    localparam int RndW  = SumW - RoundShift;

    typedef logic [AngW-1:0] angle_t;

    typedef enum logic
    {
        CMD_TO_POLAR = 1'b0,
        CMD_TO_RECT  = 1'b1
    } cmd_t;

    // Payload handed from cell to cell.
    typedef struct packed
    {
        cmd_t                    cmd;
        logic signed [DataW-1:0] x;
        logic signed [DataW-1:0] y;
        angle_t                  z;
        logic                    byp;
        logic [ResW-1:0]         byp_first;
        logic [ResW-1:0]         byp_second;
    } cordic_t;

    // round(atan(2^-i) / (2*pi) * 2^32)
    function automatic angle_t atan_turn(input logic [ShiftW-1:0] idx);
        angle_t r;
        unique case (idx)
            5'd0:    r = 32'h20000000;
            5'd1:    r = 32'h12E4051E;
            5'd2:    r = 32'h09FB385B;
            5'd3:    r = 32'h051111D4;
            5'd4:    r = 32'h028B0D43;
            5'd5:    r = 32'h0145D7E1;
            5'd6:    r = 32'h00A2F61E;
            5'd7:    r = 32'h00517C55;
            5'd8:    r = 32'h0028BE53;
            5'd9:    r = 32'h00145F2F;
            5'd10:   r = 32'h000A2F98;
            5'd11:   r = 32'h000517CC;
            5'd12:   r = 32'h00028BE6;
            5'd13:   r = 32'h000145F3;
            5'd14:   r = 32'h0000A2FA;
            5'd15:   r = 32'h0000517D;
            5'd16:   r = 32'h000028BE;
            5'd17:   r = 32'h0000145F;
            5'd18:   r = 32'h00000A30;
            5'd19:   r = 32'h00000518;
            5'd20:   r = 32'h0000028C;
            5'd21:   r = 32'h00000146;
            5'd22:   r = 32'h000000A3;
            5'd23:   r = 32'h00000051;
            default: r = '0;
        endcase
        return r;
    endfunction

endpackage

`default_nettype wire

/* rtl/crpc_prep.sv */
`default_nettype none

module crpc_prep
(
    input  wire logic                      clk,
    input  wire logic                      rst_n,
    input  wire logic                      in_valid,
    output logic                           in_ready,
    input  wire crpc_pkg::cmd_t            in_cmd,
    input  wire logic [crpc_pkg::InW-1:0]  in_first,
    input  wire logic [crpc_pkg::InW-1:0]  in_second,
    output logic                           out_valid,
    input  wire logic                      out_ready,
    output crpc_pkg::cordic_t              out_data
);
    import crpc_pkg::*;

    logic    valid_reg;
    cordic_t data_reg;
    cordic_t data_next;

    logic signed [InW:0] a17;
    logic signed [InW:0] b17;
    logic signed [InW:0] a_abs;
    logic signed [InW:0] b_abs;
    logic signed [InW:0] vx;
    logic signed [InW:0] vy;
    angle_t              z_rect;

    assign in_ready  = !valid_reg || out_ready;
    assign out_valid = valid_reg;
    assign out_data  = data_reg;

    always_comb
    begin
        a17    = {in_first[InW-1], in_first};
        b17    = {in_second[InW-1], in_second};
        a_abs  = a17[InW] ? -a17 : a17;
        b_abs  = b17[InW] ? -b17 : b17;
        z_rect = {in_second, {(AngW-InW){1'b0}}};

        data_next            = '0;
        data_next.cmd        = in_cmd;
        data_next.byp        = 1'b0;
        data_next.byp_first  = '0;
        data_next.byp_second = '0;
        vx = a17;
        vy = '0;

        unique case (in_cmd)
            CMD_TO_POLAR:
            begin
                // Vectors on an axis take the exact answer and skip the rotations.
                if (b17 == '0)
                begin
                    data_next.byp       = 1'b1;
                    data_next.byp_first = a_abs;
                    data_next.byp_second = (a17 > 0 || a17 == 0) ? '0
                                           : ResW'(-(1 << (InW-1)));
                end
                else if (a17 == '0)
                begin
                    data_next.byp        = 1'b1;
                    data_next.byp_first  = b_abs;
                    data_next.byp_second = b17[InW] ? ResW'(-(1 << (InW-2)))
                                           : ResW'(1 << (InW-2));
                end
                // Left half-plane: negate the vector and start the angle at pi.
                if (a17[InW])
                begin
                    vx          = -a17;
                    vy          = -b17;
                    data_next.z = {1'b1, {(AngW-1){1'b0}}};
                end
                else
                begin
                    vx          = a17;
                    vy          = b17;
                    data_next.z = '0;
                end
            end
            CMD_TO_RECT:
            begin
                // Angles in the left half-turn rotate the negated magnitude by a - pi.
                data_next.z = z_rect;
                vy = '0;
                if (z_rect[AngW-1] != z_rect[AngW-2])
                begin
                    vx                   = -a17;
                    data_next.z[AngW-1]  = ~z_rect[AngW-1];
                end
                else
                begin
                    vx = a17;
                end
            end
            default:
            begin
                vx = a17;
            end
        endcase

        data_next.x = {{(DataW-InW-1-FracW){vx[InW]}}, vx, {FracW{1'b0}}};
        data_next.y = {{(DataW-InW-1-FracW){vy[InW]}}, vy, {FracW{1'b0}}};
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            valid_reg <= 1'b0;
        end
        else if (in_ready)
        begin
            valid_reg <= in_valid;
        end
    end

    always_ff @(posedge clk)
    begin
        if (in_ready && in_valid)
        begin
            data_reg <= data_next;
        end
    end

endmodule

`default_nettype wire

/* rtl/crpc_cell.sv */
`default_nettype none

module crpc_cell
(
    input  wire logic                         clk,
    input  wire logic                         rst_n,
    input  wire logic [crpc_pkg::ShiftW-1:0]  shift,
    input  wire crpc_pkg::angle_t             atan,
    input  wire logic                         in_valid,
    output logic                              in_ready,
    input  wire crpc_pkg::cordic_t            in_data,
    output logic                              out_valid,
    input  wire logic                         out_ready,
    output crpc_pkg::cordic_t                 out_data
);
    import crpc_pkg::*;

    logic    valid_reg;
    cordic_t data_reg;
    cordic_t data_next;

    logic signed [DataW-1:0] dx;
    logic signed [DataW-1:0] dy;
    logic                    rot_neg;

    assign in_ready  = !valid_reg || out_ready;
    assign out_valid = valid_reg;
    assign out_data  = data_reg;

    always_comb
    begin
        dx = in_data.y >>> shift;
        dy = in_data.x >>> shift;

        // Vectoring drives y toward zero; rotation drives z toward zero.
        unique case (in_data.cmd)
            CMD_TO_POLAR: rot_neg = !in_data.y[DataW-1];
            CMD_TO_RECT:  rot_neg = in_data.z[AngW-1];
            default:      rot_neg = 1'b0;
        endcase

        data_next = in_data;
        if (rot_neg)
        begin
            data_next.x = in_data.x + dx;
            data_next.y = in_data.y - dy;
            data_next.z = in_data.z + atan;
        end
        else
        begin
            data_next.x = in_data.x - dx;
            data_next.y = in_data.y + dy;
            data_next.z = in_data.z - atan;
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            valid_reg <= 1'b0;
        end
        else if (in_ready)
        begin
            valid_reg <= in_valid;
        end
    end

    always_ff @(posedge clk)
    begin
        if (in_ready && in_valid)
        begin
            data_reg <= data_next;
        end
    end

endmodule

`default_nettype wire

/* rtl/crpc_descale.sv */
`default_nettype none

module crpc_descale
(
    input  wire logic                        clk,
    input  wire logic                        rst_n,
    input  wire logic                        in_valid,
    output logic                             in_ready,
    input  wire crpc_pkg::cordic_t           in_data,
    output logic                             out_valid,
    input  wire logic                        out_ready,
    output logic [crpc_pkg::ResW-1:0]        out_first,
    output logic [crpc_pkg::ResW-1:0]        out_second
);
    import crpc_pkg::*;

    // Stage one: partial products of the gain correction.
    logic                   va_reg;
    logic signed [HiPW-1:0] phx_reg;
    logic        [LoPW-1:0] plx_reg;
    logic signed [HiPW-1:0] phy_reg;
    logic        [LoPW-1:0] ply_reg;
    cmd_t                   cmd_reg;
    logic                   byp_reg;
    logic [ResW-1:0]        byp_first_reg;
    logic [ResW-1:0]        byp_second_reg;
    logic [ResW-1:0]        ang_reg;
    logic                   ready_a;

    // Stage two: output register.
    logic                   vb_reg;
    logic [ResW-1:0]        first_reg;
    logic [ResW-1:0]        second_reg;
    logic [ResW-1:0]        first_next;
    logic [ResW-1:0]        second_next;
    logic                   ready_b;

    angle_t                 z_rnd;
    logic [ResW-1:0]        mag_x;
    logic [ResW-1:0]        mag_y;

    function automatic logic [ResW-1:0] finish(input logic signed [HiPW-1:0] ph,
                                               input logic [LoPW-1:0] pl);
        logic signed [SumW-1:0] sum;
        logic signed [RndW-1:0] rnd;
        logic [ResW-1:0]        r;
        sum = (SumW'(ph) <<< LoW) + SumW'({1'b0, pl}) + (SumW'(1) <<< (RoundShift-1));
        rnd = sum[SumW-1:RoundShift];
        if (rnd > RndW'(OutLimit))
        begin
            r = ResW'(OutLimit);
        end
        else if (rnd < -RndW'(OutLimit))
        begin
            r = ResW'(-OutLimit);
        end
        else
        begin
            r = rnd[ResW-1:0];
        end
        return r;
    endfunction

    assign ready_b    = !vb_reg || out_ready;
    assign ready_a    = !va_reg || ready_b;
    assign in_ready   = ready_a;
    assign out_valid  = vb_reg;
    assign out_first  = first_reg;
    assign out_second = second_reg;

    assign z_rnd = in_data.z + angle_t'(1 << (AngW-InW-1));

    always_comb
    begin
        mag_x = finish(phx_reg, plx_reg);
        mag_y = finish(phy_reg, ply_reg);
        if (byp_reg)
        begin
            first_next  = byp_first_reg;
            second_next = byp_second_reg;
        end
        else
        begin
            first_next = mag_x;
            unique case (cmd_reg)
                CMD_TO_POLAR: second_next = ang_reg;
                CMD_TO_RECT:  second_next = mag_y;
                default:      second_next = mag_y;
            endcase
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            va_reg <= 1'b0;
            vb_reg <= 1'b0;
        end
        else
        begin
            if (ready_a)
            begin
                va_reg <= in_valid;
            end
            if (ready_b)
            begin
                vb_reg <= va_reg;
            end
        end
    end

    always_ff @(posedge clk)
    begin
        if (ready_a && in_valid)
        begin
            phx_reg        <= $signed(in_data.x[DataW-1:LoW]) * $signed({1'b0, KINV});
            plx_reg        <= in_data.x[LoW-1:0] * KINV;
            phy_reg        <= $signed(in_data.y[DataW-1:LoW]) * $signed({1'b0, KINV});
            ply_reg        <= in_data.y[LoW-1:0] * KINV;
            cmd_reg        <= in_data.cmd;
            byp_reg        <= in_data.byp;
            byp_first_reg  <= in_data.byp_first;
            byp_second_reg <= in_data.byp_second;
            ang_reg        <= {z_rnd[AngW-1], z_rnd[AngW-1:AngW-InW]};
        end
        if (ready_b && va_reg)
        begin
            first_reg  <= first_next;
            second_reg <= second_next;
        end
    end

endmodule

`default_nettype wire

/* rtl/complex_rect_polar_converter_top.sv */
// Channel | Direction | Ports                  | Contents
// s       | in        | s_tvalid/tready/tdata  | tdata: in_first, in_second; tuser: cmd
// m       | out       | m_tvalid/tready/tdata  | tdata: out_first, out_second
//
// One beat is accepted per cycle while s_tready is high; each beat yields one
// result beat after one preparation stage, one cell per micro-rotation and
// two stages of gain multiplication. Each stage holds its beat while the next
// one is stalled, so bubbles collapse and a stalled output blocks the input
// only once every stage is full. Reset clears all stage valid flags.
`default_nettype none

module complex_rect_polar_converter_top
(
    input  wire logic        clk,
    input  wire logic        rst_n,
    input  wire logic        s_tvalid,
    output logic             s_tready,
    input  wire logic [31:0] s_tdata,   // [15:0] in_first, [31:16] in_second
    input  wire logic [0:0]  s_tuser,   // [0] cmd
    output logic             m_tvalid,
    input  wire logic        m_tready,
    output logic [39:0]      m_tdata    // [16:0] out_first, [33:17] out_second
);
    import crpc_pkg::*;

    cordic_t             chain_data  [NumCells+1];
    logic [NumCells:0]   chain_valid;
    logic [NumCells:0]   chain_ready;
    logic [ResW-1:0]     res_first;
    logic [ResW-1:0]     res_second;

    crpc_prep u_prep
    (
        .clk       (clk),
        .rst_n     (rst_n),
        .in_valid  (s_tvalid),
        .in_ready  (s_tready),
        .in_cmd    (cmd_t'(s_tuser[0])),
        .in_first  (s_tdata[InW-1:0]),
        .in_second (s_tdata[2*InW-1:InW]),
        .out_valid (chain_valid[0]),
        .out_ready (chain_ready[0]),
        .out_data  (chain_data[0])
    );

    for (genvar i = 0; i < NumCells; i++)
    begin : g_cell
        crpc_cell u_cell
        (
            .clk       (clk),
            .rst_n     (rst_n),
            .shift     (ShiftW'(i)),
            .atan      (atan_turn(ShiftW'(i))),
            .in_valid  (chain_valid[i]),
            .in_ready  (chain_ready[i]),
            .in_data   (chain_data[i]),
            .out_valid (chain_valid[i+1]),
            .out_ready (chain_ready[i+1]),
            .out_data  (chain_data[i+1])
        );
    end

    crpc_descale u_descale
    (
        .clk        (clk),
        .rst_n      (rst_n),
        .in_valid   (chain_valid[NumCells]),
        .in_ready   (chain_ready[NumCells]),
        .in_data    (chain_data[NumCells]),
        .out_valid  (m_tvalid),
        .out_ready  (m_tready),
        .out_first  (res_first),
        .out_second (res_second)
    );

    assign m_tdata = {{(40-2*ResW){1'b0}}, res_second, res_first};

endmodule

`default_nettype wire

/* tb/tb_top.sv */
`timescale 1ns / 100ps

module tb_top;

    import crpc_pkg::*;

    localparam int      Rotations  = NumCells;
    localparam int      Latency    = NumCells + 3;
    localparam longint  GainInv    = 64'sd652032874;
    localparam longint  SatLimit   = 64'sd46341;
    localparam longint  CycleLimit = 400000;

    typedef struct packed
    {
        logic [16:0] first;
        logic [16:0] second;
    } conv_result_t;

    typedef enum logic [1:0]
    {
        READY_ALWAYS,
        READY_RANDOM,
        READY_SPARSE,
        READY_HOLD
    } ready_mode_t;

    logic        clk      = 1'b0;
    logic        rst_n    = 1'b0;
    logic        s_tvalid = 1'b0;
    logic        s_tready;
    logic [31:0] s_tdata  = '0;     // [15:0] in_first, [31:16] in_second
    logic [0:0]  s_tuser  = '0;     // [0] cmd
    logic        m_tvalid;
    logic        m_tready = 1'b0;
    logic [39:0] m_tdata;           // [16:0] out_first, [33:17] out_second

    conv_result_t pending_results[$];
    int           mismatch_count = 0;
    int           burst_left     = 0;
    longint       cycle_count    = 0;
    ready_mode_t  ready_mode     = READY_ALWAYS;
    int           ready_left     = 0;

    complex_rect_polar_converter_top dut
    (
        .clk      (clk),
        .rst_n    (rst_n),
        .s_tvalid (s_tvalid),
        .s_tready (s_tready),
        .s_tdata  (s_tdata),
        .s_tuser  (s_tuser),
        .m_tvalid (m_tvalid),
        .m_tready (m_tready),
        .m_tdata  (m_tdata)
    );

    always
    begin
        #10 clk = 1'b1;
        #10 clk = 1'b0;
    end

    // Arctangent of 2^-i as a fraction of a full turn, scaled to 2^32.
    function automatic logic [31:0] atan_of_step(input int i);
        logic [31:0] r;
        case (i)
            0:       r = 32'h20000000;
            1:       r = 32'h12E4051E;
            2:       r = 32'h09FB385B;
            3:       r = 32'h051111D4;
            4:       r = 32'h028B0D43;
            5:       r = 32'h0145D7E1;
            6:       r = 32'h00A2F61E;
            7:       r = 32'h00517C55;
            8:       r = 32'h0028BE53;
            9:       r = 32'h00145F2F;
            10:      r = 32'h000A2F98;
            11:      r = 32'h000517CC;
            12:      r = 32'h00028BE6;
            13:      r = 32'h000145F3;
            14:      r = 32'h0000A2FA;
            15:      r = 32'h0000517D;
            16:      r = 32'h000028BE;
            17:      r = 32'h0000145F;
            18:      r = 32'h00000A30;
            19:      r = 32'h00000518;
            20:      r = 32'h0000028C;
            21:      r = 32'h00000146;
            22:      r = 32'h000000A3;
            23:      r = 32'h00000051;
            default: r = 32'h0;
        endcase
        return r;
    endfunction

    // Undo the CORDIC gain, round half up and clamp to the result range.
    function automatic longint remove_gain(input longint v);
        longint p;
        p = (v * GainInv + (64'sd1 <<< 45)) >>> 46;
        if (p > SatLimit)
            p = SatLimit;
        else if (p < -SatLimit)
            p = -SatLimit;
        return p;
    endfunction

    function automatic conv_result_t cordic_to_polar(input longint x_in, input longint y_in);
        conv_result_t r;
        longint       x;
        longint       y;
        longint       dx;
        longint       dy;
        logic [31:0]  z;
        logic [31:0]  zr;
        int           i;
        x = x_in;
        y = y_in;
        z = '0;
        if (x == 0 && y == 0)
        begin
            r.first  = '0;
            r.second = '0;
        end
        else if (y == 0)
        begin
            r.first  = (x > 0) ? x[16:0] : 17'(-x);
            r.second = (x > 0) ? 17'd0 : 17'h18000;
        end
        else if (x == 0)
        begin
            r.first  = (y > 0) ? y[16:0] : 17'(-y);
            r.second = (y > 0) ? 17'h04000 : 17'h1C000;
        end
        else
        begin
            // Vectors left of the imaginary axis are mirrored and start at pi.
            if (x < 0)
            begin
                x = -x;
                y = -y;
                z = 32'h80000000;
            end
            x = x * 65536;
            y = y * 65536;
            for (i = 0; i < Rotations; i++)
            begin
                dx = y >>> i;
                dy = x >>> i;
                if (y >= 0)
                begin
                    x = x + dx;
                    y = y - dy;
                    z = z + atan_of_step(i);
                end
                else
                begin
                    x = x - dx;
                    y = y + dy;
                    z = z - atan_of_step(i);
                end
            end
            x        = remove_gain(x);
            zr       = z + 32'h00008000;
            r.first  = x[16:0];
            r.second = {zr[31], zr[31:16]};
        end
        return r;
    endfunction

    function automatic conv_result_t cordic_to_rect(input longint m_in, input logic [15:0] a_in);
        conv_result_t r;
        longint       m;
        longint       x;
        longint       y;
        longint       dx;
        longint       dy;
        logic [31:0]  z;
        logic [31:0]  zt;
        int           i;
        m  = m_in;
        z  = {a_in, 16'h0000};
        zt = z + 32'h40000000;
        // Angles in the left half-turn: flip the magnitude and rotate by pi.
        if (zt[31])
        begin
            m = -m;
            z = z - 32'h80000000;
        end
        x = m * 65536;
        y = 0;
        for (i = 0; i < Rotations; i++)
        begin
            dx = y >>> i;
            dy = x >>> i;
            if (!z[31])
            begin
                x = x - dx;
                y = y + dy;
                z = z - atan_of_step(i);
            end
            else
            begin
                x = x + dx;
                y = y - dy;
                z = z + atan_of_step(i);
            end
        end
        x        = remove_gain(x);
        y        = remove_gain(y);
        r.first  = x[16:0];
        r.second = y[16:0];
        return r;
    endfunction

    function automatic conv_result_t expected_conversion(input cmd_t c, input logic [15:0] f,
                                                         input logic [15:0] s);
        if (c == CMD_TO_POLAR)
            return cordic_to_polar(longint'($signed(f)), longint'($signed(s)));
        else
            return cordic_to_rect(longint'($signed(f)), s);
    endfunction

    task automatic report_mismatch(input string what, input logic [16:0] got,
                                   input logic [16:0] want);
        if (mismatch_count < 40)
            $display("%0t mismatch: %s got %0d expected %0d", $realtime, what,
                     $signed(got), $signed(want));
        mismatch_count++;
    endtask

    // Sends one beat in bursts of random length separated by random gaps.
    task automatic send_beat(input cmd_t c, input int f, input int s);
        int          gap;
        logic [15:0] fv;
        logic [15:0] sv;
        fv = f[15:0];
        sv = s[15:0];
        if (burst_left == 0)
        begin
            gap = ($urandom_range(0, 3) == 0) ? 0 : $urandom_range(1, 8);
            if (gap > 0)
            begin
                s_tvalid <= 1'b0;
                repeat (gap) @(posedge clk);
            end
            burst_left = ($urandom_range(0, 4) == 0) ? $urandom_range(20, 60)
                                                      : $urandom_range(1, 8);
        end
        burst_left--;
        s_tvalid <= 1'b1;
        s_tdata  <= {sv, fv};
        s_tuser  <= c;
        @(posedge clk);
        while (!s_tready)
            @(posedge clk);
        pending_results.push_back(expected_conversion(c, fv, sv));
    endtask

    function automatic int random_coord();
        int v;
        case ($urandom_range(0, 9))
            0, 1, 2, 3, 4: v = $urandom_range(0, 65535);
            5, 6:          v = $urandom_range(0, 128) - 64;
            7:
            begin
                case ($urandom_range(0, 5))
                    0:       v = -32768;
                    1:       v = -32767;
                    2:       v = 32767;
                    3:       v = -1;
                    4:       v = 1;
                    default: v = 32766;
                endcase
            end
            8:             v = 0;
            default:       v = ($urandom_range(0, 1) ? 1 : -1) * (1 << $urandom_range(0, 14));
        endcase
        return v;
    endfunction

    // Angles cluster now and then around the quadrant boundaries.
    function automatic int random_angle();
        int v;
        if ($urandom_range(0, 3) == 0)
            v = 16384 * $urandom_range(0, 3) + $urandom_range(0, 4) - 2;
        else
            v = $urandom_range(0, 65535);
        return v;
    endfunction

    task automatic test_rect_to_polar_corners();
        send_beat(CMD_TO_POLAR, 0, 0);
        send_beat(CMD_TO_POLAR, 5, 0);
        send_beat(CMD_TO_POLAR, -5, 0);
        send_beat(CMD_TO_POLAR, 0, 7);
        send_beat(CMD_TO_POLAR, 0, -7);
        send_beat(CMD_TO_POLAR, -32768, 0);
        send_beat(CMD_TO_POLAR, 0, -32768);
        send_beat(CMD_TO_POLAR, 32767, 32767);
        send_beat(CMD_TO_POLAR, -32768, -32768);
        send_beat(CMD_TO_POLAR, -32768, 32767);
        send_beat(CMD_TO_POLAR, 32767, -32768);
        send_beat(CMD_TO_POLAR, -1, 1);
        send_beat(CMD_TO_POLAR, 1, -1);
    endtask

    task automatic test_polar_to_rect_corners();
        send_beat(CMD_TO_RECT, 32767, 0);
        send_beat(CMD_TO_RECT, 32767, 16384);
        send_beat(CMD_TO_RECT, 32767, -32768);
        send_beat(CMD_TO_RECT, 32767, -16384);
        send_beat(CMD_TO_RECT, -32768, 12345);
        send_beat(CMD_TO_RECT, -32768, -32768);
        send_beat(CMD_TO_RECT, 0, 5000);
        send_beat(CMD_TO_RECT, 1000, 16383);
        send_beat(CMD_TO_RECT, 1000, -16385);
    endtask

    task automatic test_random_to_polar(input int count);
        int n;
        for (n = 0; n < count; n++)
            send_beat(CMD_TO_POLAR, random_coord(), random_coord());
    endtask

    task automatic test_random_to_rect(input int count);
        int n;
        for (n = 0; n < count; n++)
            send_beat(CMD_TO_RECT, random_coord(), random_angle());
    endtask

    task automatic test_random_mixed(input int count);
        int n;
        for (n = 0; n < count; n++)
        begin
            if ($urandom_range(0, 1))
                send_beat(CMD_TO_RECT, random_coord(), random_angle());
            else
                send_beat(CMD_TO_POLAR, random_coord(), random_coord());
        end
    endtask

    // The receiver switches between stall patterns of random duration.
    always @(posedge clk)
    begin
        if (ready_left == 0)
        begin
            ready_mode = ready_mode_t'($urandom_range(0, 3));
            ready_left = (ready_mode == READY_HOLD) ? $urandom_range(1, 40)
                                                    : $urandom_range(10, 120);
        end
        ready_left--;
        case (ready_mode)
            READY_ALWAYS: m_tready <= 1'b1;
            READY_RANDOM: m_tready <= 1'($urandom_range(0, 1));
            READY_SPARSE: m_tready <= ($urandom_range(0, 3) == 0);
            default:      m_tready <= 1'b0;
        endcase
    end

    always @(posedge clk)
    begin
        conv_result_t want;
        conv_result_t got;
        got = {m_tdata[16:0], m_tdata[33:17]};
        if (rst_n && m_tvalid && m_tready)
        begin
            if (pending_results.size() == 0)
                report_mismatch("result beat with none pending, out_first", got.first, '0);
            else
            begin
                want = pending_results.pop_front();
                if (got.first !== want.first)
                    report_mismatch("out_first", got.first, want.first);
                if (got.second !== want.second)
                    report_mismatch("out_second", got.second, want.second);
            end
        end
    end

    always @(posedge clk)
    begin
        cycle_count++;
        if (cycle_count > CycleLimit)
        begin
            $display("** complex_rect_polar_converter_top: FAILED **");
            $finish;
        end
    end

    initial
    begin
        repeat (4) @(posedge clk);
        rst_n <= 1'b1;
        @(posedge clk);
        test_rect_to_polar_corners();
        test_polar_to_rect_corners();
        test_random_to_polar(600);
        test_random_to_rect(600);
        test_random_mixed(800);
        s_tvalid <= 1'b0;
        while (pending_results.size() != 0)
            @(posedge clk);
        // Any stray beat still in the pipeline would show up here.
        repeat (Latency + 10) @(posedge clk);
        if (mismatch_count == 0)
            $display("** complex_rect_polar_converter_top: PASSED **");
        else
            $display("** complex_rect_polar_converter_top: FAILED **");
        $finish;
    end

endmodule

/* complex_rect_polar_converter_top.f */
rtl/crpc_pkg.sv
rtl/crpc_prep.sv
rtl/crpc_cell.sv
rtl/crpc_descale.sv
rtl/complex_rect_polar_converter_top.sv
tb/tb_top.sv
